FILE: rtl/ip_address_to_text_core_macros.svh
// assertion macros for the ip address to text core
// expects clk and rst_n in the scope of each use
`ifndef IP_ADDRESS_TO_TEXT_CORE_MACROS_SVH
`define IP_ADDRESS_TO_TEXT_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define IATT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define IATT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/iatt_pkg.sv
// shared widths, codes and digit helpers for the ip address to text core
// no dependencies
`timescale 1ns / 1ps

package iatt_pkg;

    localparam int FAMILY_W = 2;
    localparam int HALF_W   = 64;
    localparam int SIZE_W   = 8;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [FAMILY_W-1:0] FAM_V4 = 2'd0;
    localparam logic [FAMILY_W-1:0] FAM_V6 = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNSUP   = 2'd2;

    localparam logic [SIZE_W-1:0] V4_MIN_SIZE = 8'd16;
    localparam logic [SIZE_W-1:0] V6_MIN_SIZE = 8'd46;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;

    // position of the leading decimal digit of a byte (0 ones, 2 hundreds)
    function automatic logic [1:0] dec_top(input logic [7:0] v);
        logic [1:0] pos;
        if (v >= 8'd100)
            pos = 2'd2;
        else if (v >= 8'd10)
            pos = 2'd1;
        else
            pos = 2'd0;
        return pos;
    endfunction

    // one decimal digit of a byte; divide by ten via reciprocal multiply
    function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  o;
        logic [3:0]  d;
        if (v >= 8'd200)
            h = 2'd2;
        else if (v >= 8'd100)
            h = 2'd1;
        else
            h = 2'd0;
        r = 7'(v - 8'(h) * 8'd100);
        p = 15'(r) * 15'd205;
        t = 4'(p >> 11);
        o = 4'(r - 7'(t) * 7'd10);
        unique case (pos)
            2'd2:    d = 4'(h);
            2'd1:    d = t;
            default: d = o;
        endcase
        return d;
    endfunction

    // position of the leading significant nibble of a group
    function automatic logic [1:0] hex_top(input logic [15:0] g);
        logic [1:0] pos;
        if (g[15:12] != 4'd0)
            pos = 2'd3;
        else if (g[11:8] != 4'd0)
            pos = 2'd2;
        else if (g[7:4] != 4'd0)
            pos = 2'd1;
        else
            pos = 2'd0;
        return pos;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [15:0] g, input logic [1:0] pos);
        logic [3:0] d;
        logic [CHAR_W-1:0] c;
        unique case (pos)
            2'd3:    d = g[15:12];
            2'd2:    d = g[11:8];
            2'd1:    d = g[7:4];
            default: d = g[3:0];
        endcase
        if (d < 4'd10)
            c = CH_ZERO + 8'(d);
        else
            c = CH_LOW_A + 8'(d) - 8'd10;
        return c;
    endfunction

endpackage

FILE: rtl/iatt_chan_if.sv
// valid/ready channel interfaces for the address input and the text output
// depends on iatt_pkg
`timescale 1ns / 1ps

interface iatt_in_if;
    import iatt_pkg::*;

    logic                valid;
    logic                ready;
    logic [FAMILY_W-1:0] family;
    logic [HALF_W-1:0]   addr_hi;
    logic [HALF_W-1:0]   addr_lo;
    logic [SIZE_W-1:0]   buffer_size;

    modport source (output valid, family, addr_hi, addr_lo, buffer_size, input ready);
    modport sink   (input valid, family, addr_hi, addr_lo, buffer_size, output ready);
endinterface

interface iatt_out_if;
    import iatt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   text_char;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, text_char, status, last, input ready);
    modport sink   (input valid, text_char, status, last, output ready);
endinterface

FILE: rtl/ip_address_to_text_core.sv
// ip address to text: ipv4 has a setup state, then one character per cycle if ready
// ipv6 searches all 8 groups for the longest zero run (one group per cycle), then
// the setup state, then one character per cycle if ready: up to 39 characters
// errors give one NUL character; the single output register sets the character rate
// ready only while idle; a new address may enter while the last character still waits
// reset (rst_n low, async) returns to idle with no output pending
`timescale 1ns / 1ps

`include "ip_address_to_text_core_macros.svh"

module ip_address_to_text_core (
    input  logic       clk,
    input  logic       rst_n,
    iatt_in_if.sink    in_ch,
    iatt_out_if.source out_ch
);
    import iatt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_LOAD   = 5'b00100,
        S_EMIT   = 5'b01000,
        S_FAIL   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [127:0]        addr_reg, addr_next;
    logic                v6_reg, v6_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [2:0]          si_reg, si_next;
    logic [3:0]          cur_len_reg, cur_len_next;
    logic [2:0]          cur_start_reg, cur_start_next;
    logic [3:0]          best_len_reg, best_len_next;
    logic [2:0]          best_idx_reg, best_idx_next;
    logic [3:0]          gi_reg, gi_next;
    logic [1:0]          sep_cnt_reg, sep_cnt_next;
    logic [1:0]          dig_reg, dig_next;
    logic                comp_reg, comp_next;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                last_reg, last_next;

    logic [7:0][15:0]    grp;
    logic [3:0][7:0]     bytes;
    logic                slot_free;
    logic                in_xfer;

    // next element bookkeeping
    logic [3:0]          ent_idx;
    logic                ent_nosep;
    logic [15:0]         ent_grp;
    logic [7:0]          ent_byte;
    logic                ent_done;
    logic                ent_comp;
    logic [1:0]          ent_sep;
    logic [1:0]          ent_dig;

    logic [15:0]         cur_grp;
    logic [7:0]          cur_byte;
    logic [CHAR_W-1:0]   cur_char;
    logic [15:0]         srch_grp;
    logic [3:0]          run_len;

    assign grp       = addr_reg;
    assign bytes     = addr_reg[127:96];
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_xfer   = in_ch.valid && in_ch.ready;

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.text_char = char_reg;
    assign out_ch.status    = status_reg;
    assign out_ch.last      = last_reg;

    // group 0 sits in the top bits, hence the inverted index
    assign srch_grp = grp[~si_reg];
    assign run_len  = cur_len_reg + 4'd1;
    assign cur_grp  = grp[~gi_reg[2:0]];
    assign cur_byte = bytes[~gi_reg[1:0]];
    assign cur_char = v6_reg ? hex_char(cur_grp, dig_reg)
                             : CH_ZERO + 8'(dec_digit(cur_byte, dig_reg));

    always_comb
    begin
        ent_idx   = gi_reg;
        ent_nosep = 1'b0;
        if (state_reg == S_EMIT)
        begin
            if (sep_cnt_reg != 2'd0)
            begin
                // after "::" skip the whole zero run
                ent_idx   = gi_reg + best_len_reg;
                ent_nosep = 1'b1;
            end
            else
            begin
                ent_idx = gi_reg + 4'd1;
            end
        end
    end

    assign ent_grp  = grp[~ent_idx[2:0]];
    assign ent_byte = bytes[~ent_idx[1:0]];
    assign ent_done = v6_reg ? ent_idx[3] : (ent_idx[3] || ent_idx[2]);
    assign ent_comp = v6_reg && (best_len_reg != 4'd0) && (ent_idx[2:0] == best_idx_reg)
                      && !ent_done;
    assign ent_sep  = ent_comp ? 2'd2 : (((ent_idx != 4'd0) && !ent_nosep) ? 2'd1 : 2'd0);
    assign ent_dig  = v6_reg ? hex_top(ent_grp) : dec_top(ent_byte);

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        v6_next        = v6_reg;
        err_next       = err_reg;
        si_next        = si_reg;
        cur_len_next   = cur_len_reg;
        cur_start_next = cur_start_reg;
        best_len_next  = best_len_reg;
        best_idx_next  = best_idx_reg;
        gi_next        = gi_reg;
        sep_cnt_next   = sep_cnt_reg;
        dig_next       = dig_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        char_next      = char_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    addr_next      = {in_ch.addr_hi, in_ch.addr_lo};
                    v6_next        = (in_ch.family == FAM_V6);
                    si_next        = 3'd0;
                    cur_len_next   = 4'd0;
                    cur_start_next = 3'd0;
                    best_len_next  = 4'd0;
                    best_idx_next  = 3'd0;
                    gi_next        = 4'd0;
                    if (in_ch.family == FAM_V4)
                    begin
                        err_next   = STAT_NOSPACE;
                        state_next = (in_ch.buffer_size < V4_MIN_SIZE) ? S_FAIL : S_LOAD;
                    end
                    else if (in_ch.family == FAM_V6)
                    begin
                        err_next   = STAT_NOSPACE;
                        state_next = (in_ch.buffer_size < V6_MIN_SIZE) ? S_FAIL : S_SEARCH;
                    end
                    else
                    begin
                        err_next   = STAT_UNSUP;
                        state_next = S_FAIL;
                    end
                end
            end
            S_SEARCH:
            begin
                // strict compare keeps the earliest of equally long runs
                if (srch_grp == 16'd0)
                begin
                    cur_len_next = run_len;
                    if (cur_len_reg == 4'd0)
                        cur_start_next = si_reg;
                    if ((run_len > best_len_reg) && (run_len > 4'd1))
                    begin
                        best_len_next = run_len;
                        best_idx_next = cur_start_reg;
                    end
                end
                else
                begin
                    cur_len_next = 4'd0;
                end
                si_next = si_reg + 3'd1;
                if (si_reg == 3'd7)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                sep_cnt_next = ent_sep;
                dig_next     = ent_dig;
                comp_next    = ent_comp;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    last_next      = 1'b0;
                    if (sep_cnt_reg != 2'd0)
                    begin
                        char_next    = v6_reg ? CH_COLON : CH_DOT;
                        sep_cnt_next = sep_cnt_reg - 2'd1;
                        if ((sep_cnt_reg == 2'd1) && comp_reg)
                        begin
                            if (ent_done)
                            begin
                                last_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                gi_next      = ent_idx;
                                sep_cnt_next = ent_sep;
                                dig_next     = ent_dig;
                                comp_next    = ent_comp;
                            end
                        end
                    end
                    else
                    begin
                        char_next = cur_char;
                        if (dig_reg == 2'd0)
                        begin
                            if (ent_done)
                            begin
                                last_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                gi_next      = ent_idx;
                                sep_cnt_next = ent_sep;
                                dig_next     = ent_dig;
                                comp_next    = ent_comp;
                            end
                        end
                        else
                        begin
                            dig_next = dig_reg - 2'd1;
                        end
                    end
                end
            end
            S_FAIL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_NUL;
                    status_next    = err_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        v6_reg        <= v6_next;
        err_reg       <= err_next;
        si_reg        <= si_next;
        cur_len_reg   <= cur_len_next;
        cur_start_reg <= cur_start_next;
        best_len_reg  <= best_len_next;
        best_idx_reg  <= best_idx_next;
        gi_reg        <= gi_next;
        sep_cnt_reg   <= sep_cnt_next;
        dig_reg       <= dig_next;
        comp_reg      <= comp_next;
        char_reg      <= char_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    `IATT_ASSERT_NXT(a_accept_busy, in_xfer, state_reg != S_IDLE, "idle after input transfer")
    `IATT_ASSERT_IMP(a_err_shape, out_ch.valid && (out_ch.status != STAT_OK),
        (out_ch.text_char == CH_NUL) && out_ch.last, "malformed error result")
    `IATT_ASSERT_IMP(a_run_len, state_reg == S_LOAD, best_len_reg != 4'd1,
        "single zero group chosen for compression")
    `IATT_ASSERT_IMP(a_emit_idx, state_reg == S_EMIT, gi_reg < 4'd8,
        "element index past the address")

endmodule
